FILE: rtl/core/rit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rit_pkg;
  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  localparam logic [0:0] REG_TIMEOUT = 1'b0;
  localparam logic [0:0] REG_SPACE   = 1'b1;

  localparam logic [15:0] TimeoutReset = 16'd500;
  localparam logic [15:0] SpaceReset   = 16'd30720;
  localparam logic [16:0] SpaceMax     = 17'd32768;
endpackage
`default_nettype wire

FILE: rtl/core/retransmit_inflight_tracker.sv
`timescale 1ns / 1ps
// send drops acked pairs, then appends to the ring, runs the modulo and adds one pair (two
// with the starting pair, none when dropped); ack scans the pairs; timeout re-stamps the
// head; query pops acked heads and gives the wait; the modulo takes 16 shift-subtract steps
// throughput: one command at a time, the next accepted the cycle after its result registers;
// a result still waiting on m_axis_tready holds the following command at its output step
// reset: asynchronous, active low; ring and pair tables empty, registers at 500 and 30720
`default_nettype none
module retransmit_inflight_tracker import rit_pkg::*; #(
  parameter int INFLIGHT_DEPTH = 16,
  parameter int PAIR_DEPTH = 32,
  parameter int HANDLE_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[1:0], now_ms[33:2], seq_num[48:34], data_size[59:49], packet_handle[67:60]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // resend_handle[7:0], resend_valid[8], wait_ms[24:9], queue_empty[25],
  // ack_unmatched[26], overflow[27]
  output logic [31:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int RW = $clog2(INFLIGHT_DEPTH);
  localparam int PW = $clog2(PAIR_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0, S_PRD = 4'd1, S_PCHK = 4'd2, S_SEND = 4'd3,
    S_MOD = 4'd4, S_ADD = 4'd5, S_ADD2 = 4'd6, S_ARD = 4'd7, S_ACHK = 4'd8,
    S_TRD = 4'd9, S_TWR = 4'd10, S_QRD = 4'd11, S_QCHK = 4'd12, S_QSUB = 4'd13,
    S_OUT = 4'd14;

  logic [3:0] st_q, st_d;
  logic [15:0] tmo_q, space_q;
  logic [31:0] now_q;
  logic [14:0] seq_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic [31:0] modv_q;
  logic [3:0] step_q;
  logic [RW-1:0] head_q;
  logic [RW:0] rcnt_q;
  logic [PW:0] pcnt_q, rd_q, wr_q;
  logic [31:0] npn_q, lack_q;
  logic first_q;
  logic [27:0] res_q, out_q;
  logic [32:0] acc_q;

  logic [HANDLE_BITS-1:0] r_hnd [INFLIGHT_DEPTH];
  logic [31:0] r_time [INFLIGHT_DEPTH];
  logic [31:0] r_pn [INFLIGHT_DEPTH];
  logic [14:0] p_seq [PAIR_DEPTH];
  logic [31:0] p_pn [PAIR_DEPTH];
  logic [14:0] p_seq_rd;
  logic [31:0] p_pn_rd;
  logic [HANDLE_BITS-1:0] r_hnd_rd;
  logic [31:0] r_time_rd, r_pn_rd;

  // shared subtract unit
  logic [32:0] sub_a, sub_b, sub_y;
  assign sub_y = sub_a - sub_b;

  logic [RW-1:0] tail;
  logic [16:0] space_eff;
  logic starting;
  assign tail = head_q + rcnt_q[RW-1:0];
  assign space_eff = (space_q == 16'd0 || {1'b0, space_q} > SpaceMax) ? SpaceMax
                                                                    : {1'b0, space_q};
  assign starting = first_q && pcnt_q == '0;

  logic in_go, out_load;
  logic [27:0] res_fin;
  assign s_axis_tready = st_q == S_IDLE;
  assign in_go = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  // result moves to the output register once the previous one has left
  assign out_load = st_q == S_OUT && (!m_axis_tvalid || m_axis_tready);
  assign res_fin = res_q | {2'b0, rcnt_q == '0, 25'd0};

  always_comb begin
    sub_a = acc_q;
    sub_b = {1'b0, modv_q};
    unique case (st_q)
      S_PCHK: begin sub_a = {1'b0, p_pn_rd}; sub_b = {1'b0, lack_q}; end
      S_QCHK: begin sub_a = {1'b0, lack_q}; sub_b = {1'b0, r_pn_rd}; end
      S_QSUB: begin sub_a = {1'b0, r_time_rd} + {17'd0, tmo_q}; sub_b = {1'b0, now_q}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_seq_rd <= p_seq[rd_q[PW-1:0]];
    p_pn_rd  <= p_pn[rd_q[PW-1:0]];
    r_hnd_rd <= r_hnd[head_q];
    r_time_rd <= r_time[head_q];
    r_pn_rd  <= r_pn[head_q];
    if (st_q == S_PCHK && !sub_y[32]) begin
      p_seq[wr_q[PW-1:0]] <= p_seq_rd;
      p_pn[wr_q[PW-1:0]]  <= p_pn_rd;
    end
    if (st_q == S_SEND && !(rcnt_q >= (RW+1)'(INFLIGHT_DEPTH)
        || pcnt_q + (starting ? 2 : 1) > PAIR_DEPTH)) begin
      r_hnd[tail] <= hnd_q;
      r_time[tail] <= now_q;
      r_pn[tail] <= npn_q;
    end
    if (st_q == S_ADD) begin
      p_seq[pcnt_q[PW-1:0]] <= starting ? seq_q : acc_q[14:0];
      p_pn[pcnt_q[PW-1:0]]  <= starting ? 32'd0 : npn_q;
    end
    if (st_q == S_ADD2) begin
      p_seq[pcnt_q[PW-1:0]] <= acc_q[14:0];
      p_pn[pcnt_q[PW-1:0]]  <= npn_q;
    end
    if (st_q == S_TWR) begin
      if (rcnt_q >= (RW+1)'(2)) begin
        r_hnd[tail] <= r_hnd_rd;
        r_time[tail] <= now_q;
        r_pn[tail] <= r_pn_rd;
      end else begin
        r_time[head_q] <= now_q;
      end
    end
    if (in_go) begin
      now_q <= s_axis_tdata[33:2];
      seq_q <= s_axis_tdata[48:34];
      hnd_q <= s_axis_tdata[60 +: HANDLE_BITS];
      acc_q <= {18'd0, s_axis_tdata[48:34]} + {22'd0, s_axis_tdata[59:49]};
    end else if (st_q == S_MOD && !sub_y[32]) begin
      acc_q <= sub_y;
    end
    // restoring remainder: space shifted left by 15, then one bit right per step
    if (st_q == S_SEND) modv_q <= {space_eff, 15'd0};
    else if (st_q == S_MOD) modv_q <= {1'b0, modv_q[31:1]};
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (in_go) begin
        unique case (cmd_e'(s_axis_tdata[1:0]))
          CMD_SEND: st_d = S_PRD;
          CMD_ACK: st_d = S_ARD;
          CMD_TIMEOUT: st_d = S_TRD;
          CMD_QUERY: st_d = S_QRD;
          default: st_d = S_IDLE;
        endcase
      end
      S_PRD: st_d = (rd_q >= pcnt_q) ? S_SEND : S_PCHK;
      S_PCHK: st_d = S_PRD;
      S_SEND: st_d = (rcnt_q >= (RW+1)'(INFLIGHT_DEPTH)
                      || pcnt_q + (starting ? 2 : 1) > PAIR_DEPTH) ? S_OUT : S_MOD;
      S_MOD: if (&step_q) st_d = S_ADD;
      S_ADD: st_d = starting ? S_ADD2 : S_OUT;
      S_ADD2: st_d = S_OUT;
      S_ARD: st_d = (rd_q >= pcnt_q) ? S_OUT : S_ACHK;
      S_ACHK: st_d = (p_seq_rd == seq_q) ? S_OUT : S_ARD;
      S_TRD: st_d = S_TWR;
      S_TWR: st_d = S_OUT;
      S_QRD: st_d = (rcnt_q == '0) ? S_OUT : S_QCHK;
      S_QCHK: st_d = sub_y[32] ? S_QSUB : S_QRD;
      S_QSUB: st_d = S_OUT;
      S_OUT: st_d = out_load ? S_IDLE : S_OUT;
      default: st_d = S_IDLE;
    endcase
  end

  logic [31:0] d32;
  assign d32 = sub_y[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      tmo_q <= TimeoutReset;
      space_q <= SpaceReset;
      head_q <= '0;
      rcnt_q <= '0;
      pcnt_q <= '0;
      rd_q <= '0;
      wr_q <= '0;
      step_q <= '0;
      npn_q <= 32'd1;
      lack_q <= '0;
      first_q <= 1'b1;
      res_q <= '0;
      out_q <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_TIMEOUT) tmo_q <= cfg_data_i;
        else if (cfg_index_i == REG_SPACE) space_q <= cfg_data_i;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        out_q <= res_fin;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: if (in_go) begin
          rd_q <= '0;
          wr_q <= '0;
          step_q <= '0;
          res_q <= '0;
        end
        S_PRD: if (rd_q >= pcnt_q) pcnt_q <= wr_q;
        S_PCHK: begin
          rd_q <= rd_q + 1'b1;
          if (!sub_y[32]) wr_q <= wr_q + 1'b1;
        end
        S_SEND: if (rcnt_q >= (RW+1)'(INFLIGHT_DEPTH)
                    || pcnt_q + (starting ? 2 : 1) > PAIR_DEPTH) begin
          res_q[27] <= 1'b1;
        end else begin
          rcnt_q <= rcnt_q + 1'b1;
        end
        S_MOD: step_q <= step_q + 1'b1;
        S_ADD: if (starting) begin
          pcnt_q <= pcnt_q + 1'b1;
          first_q <= 1'b0;
        end else begin
          pcnt_q <= pcnt_q + 1'b1;
          npn_q <= npn_q + 1'b1;
        end
        S_ADD2: begin
          pcnt_q <= pcnt_q + 1'b1;
          npn_q <= npn_q + 1'b1;
        end
        S_ARD: if (rd_q >= pcnt_q) res_q[26] <= 1'b1;
        S_ACHK: begin
          rd_q <= rd_q + 1'b1;
          if (p_seq_rd == seq_q) lack_q <= p_pn_rd;
        end
        S_TWR: if (rcnt_q != '0) begin
          res_q[7:0] <= 8'(r_hnd_rd);
          res_q[8] <= 1'b1;
          if (rcnt_q >= (RW+1)'(2)) head_q <= head_q + 1'b1;
        end
        S_QCHK: if (!sub_y[32]) begin
          head_q <= head_q + 1'b1;
          rcnt_q <= rcnt_q - 1'b1;
        end
        S_QSUB: begin
          if (d32 == 32'd0 || d32[31]) res_q[24:9] <= 16'd1;
          else if (d32[31:16] != 16'd0) res_q[24:9] <= 16'hFFFF;
          else res_q[24:9] <= d32[15:0];
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {4'd0, out_q};

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) st_q != S_IDLE |-> !s_axis_tready;
  endproperty
  assert property (p_no_accept_busy) else $error("accepted while busy");

  property p_ring_bound;
    @(posedge clk_i) disable iff (!rst_ni) rcnt_q <= (RW+1)'(INFLIGHT_DEPTH);
  endproperty
  assert property (p_ring_bound) else $error("ring count beyond depth");

  property p_pair_bound;
    @(posedge clk_i) disable iff (!rst_ni) pcnt_q <= (PW+1)'(PAIR_DEPTH);
  endproperty
  assert property (p_pair_bound) else $error("pair count beyond depth");

  property p_out_after;
    @(posedge clk_i) disable iff (!rst_ni) st_q == S_OUT |=> m_axis_tvalid;
  endproperty
  assert property (p_out_after) else $error("result not presented");
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rit_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int PAIR_SLOTS = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [7:0]  handle;
    logic        handle_valid;
    logic [15:0] wait_ms;
    logic        empty;
    logic        unmatched;
    logic        overflow;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  retransmit_inflight_tracker DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // tracker mirror
  logic [7:0]  trk_handle [RING_DEPTH];
  logic [31:0] trk_sent [RING_DEPTH];
  logic [31:0] trk_pnum [RING_DEPTH];
  int unsigned trk_head, trk_cnt;
  logic [14:0] pt_seq [PAIR_SLOTS];
  logic [31:0] pt_pnum [PAIR_SLOTS];
  int unsigned pt_cnt;
  logic [31:0] next_pnum, acked_pnum;
  logic        start_pending;
  logic [15:0] tmo_reg, space_reg;

  outcome_t expected_q[$];
  int unsigned mismatches = 0;
  logic        idle_on = 1'b1;
  int unsigned hold_request = 0;
  logic [31:0] clock_ms = 0;
  logic [14:0] next_seq = 0;

  task automatic predict_outcome(cmd_e c, logic [31:0] now, logic [14:0] seq,
                                 logic [10:0] size, logic [7:0] h);
    outcome_t o;
    int unsigned w, slot, need, space, hd, tl;
    logic start;
    logic [31:0] d;
    o = '0;
    case (c)
      CMD_SEND: begin
        w = 0;
        for (int r = 0; r < pt_cnt; r++) begin
          if (pt_pnum[r] >= acked_pnum) begin
            pt_seq[w] = pt_seq[r];
            pt_pnum[w] = pt_pnum[r];
            w++;
          end
        end
        pt_cnt = w;
        start = start_pending && pt_cnt == 0;
        need = start ? 2 : 1;
        if (trk_cnt >= RING_DEPTH || pt_cnt + need > PAIR_SLOTS) begin
          o.overflow = 1'b1;
        end else begin
          slot = (trk_head + trk_cnt) % RING_DEPTH;
          trk_handle[slot] = h;
          trk_sent[slot] = now;
          trk_pnum[slot] = next_pnum;
          trk_cnt++;
          space = space_reg;
          if (space == 0 || space > 32768) space = 32768;
          if (start) begin
            pt_seq[pt_cnt] = seq;
            pt_pnum[pt_cnt] = 0;
            pt_cnt++;
            start_pending = 1'b0;
          end
          pt_seq[pt_cnt] = 15'((int'(seq) + int'(size)) % space);
          pt_pnum[pt_cnt] = next_pnum;
          pt_cnt++;
          next_pnum++;
        end
      end
      CMD_ACK: begin
        o.unmatched = 1'b1;
        for (int i = 0; i < pt_cnt; i++) begin
          if (pt_seq[i] == seq) begin
            acked_pnum = pt_pnum[i];
            o.unmatched = 1'b0;
            break;
          end
        end
      end
      CMD_TIMEOUT: begin
        if (trk_cnt > 0) begin
          hd = trk_head;
          tl = (trk_head + trk_cnt) % RING_DEPTH;
          o.handle = trk_handle[hd];
          o.handle_valid = 1'b1;
          trk_sent[hd] = now;
          if (trk_cnt >= 2) begin
            trk_handle[tl] = trk_handle[hd];
            trk_sent[tl] = trk_sent[hd];
            trk_pnum[tl] = trk_pnum[hd];
            trk_head = (hd + 1) % RING_DEPTH;
          end
        end
      end
      default: begin
        while (trk_cnt > 0 && trk_pnum[trk_head] <= acked_pnum) begin
          trk_head = (trk_head + 1) % RING_DEPTH;
          trk_cnt--;
        end
        if (trk_cnt > 0) begin
          d = trk_sent[trk_head] + {16'd0, tmo_reg} - now;
          if (d == 0 || d[31]) o.wait_ms = 16'd1;
          else if (d > 32'hFFFF) o.wait_ms = 16'hFFFF;
          else o.wait_ms = d[15:0];
        end
      end
    endcase
    o.empty = trk_cnt == 0;
    expected_q = {expected_q, o};
  endtask

  task automatic issue_cmd(cmd_e c, logic [31:0] now, logic [14:0] seq,
                           logic [10:0] size, logic [7:0] h);
    int unsigned gap, r;
    gap = 0;
    if (idle_on) begin
      r = $urandom_range(0, 99);
      gap = r < 60 ? 0 : (r < 95 ? $urandom_range(1, 4) : $urandom_range(20, 60));
    end
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {4'd0, h, size, seq, now, c};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_outcome(c, now, seq, size, h);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (expected_q.size() > 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_TIMEOUT) tmo_reg = value;
    else space_reg = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_next(logic [10:0] size);
    issue_cmd(CMD_SEND, clock_ms, next_seq, size, 8'($urandom));
    next_seq = 15'(next_seq + size);
  endtask

  task automatic test_empty_cases();
    issue_cmd(CMD_QUERY, 32'd0, 15'd0, 11'd0, 8'd0);
    issue_cmd(CMD_TIMEOUT, 32'd5, 15'd0, 11'd0, 8'd0);
    issue_cmd(CMD_ACK, 32'd0, 15'h7FFF, 11'd0, 8'd0);
    // starting pair and extreme field values
    issue_cmd(CMD_SEND, 32'hFFFF_FFFF, 15'h7FFF, 11'd1024, 8'hFF);
    issue_cmd(CMD_ACK, 32'd0, 15'h7FFF, 11'd0, 8'd0);
    issue_cmd(CMD_QUERY, 32'hFFFF_FFF0, 15'd0, 11'd0, 8'd0);
    issue_cmd(CMD_TIMEOUT, 32'd0, 15'd0, 11'd0, 8'd0);
    issue_cmd(CMD_QUERY, 32'h8000_0000, 15'd0, 11'd0, 8'd0);
    issue_cmd(CMD_ACK, 32'd0, pt_seq[pt_cnt-1], 11'd0, 8'd0);
    issue_cmd(CMD_QUERY, 32'd10, 15'd0, 11'd0, 8'd0);
  endtask

  // ack moves backward to the first pair so pairs pile up and the table fills
  task automatic test_pair_full();
    logic [14:0] start_seq;
    next_seq = 15'd100;
    repeat (RING_DEPTH) send_next(11'($urandom_range(1, 1023)));
    start_seq = pt_seq[0];
    issue_cmd(CMD_ACK, clock_ms, pt_seq[pt_cnt-1], 11'd0, 8'd0);
    issue_cmd(CMD_QUERY, clock_ms, 15'd0, 11'd0, 8'd0);
    issue_cmd(CMD_ACK, clock_ms, start_seq, 11'd0, 8'd0);
    repeat (RING_DEPTH) send_next(11'd7);
  endtask

  task automatic test_ring_full();
    issue_cmd(CMD_ACK, clock_ms, pt_seq[pt_cnt-1], 11'd0, 8'd0);
    issue_cmd(CMD_QUERY, clock_ms, 15'd0, 11'd0, 8'd0);
    repeat (RING_DEPTH + 1) send_next(11'd0);
    issue_cmd(CMD_TIMEOUT, clock_ms, 15'd0, 11'd0, 8'd0);
  endtask

  task automatic test_random(int unsigned n, logic with_hold);
    int unsigned r, k;
    cmd_e c;
    logic [14:0] seq;
    logic [10:0] size;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_request = 500;
      if (i == n / 2) drain_results();
      r = $urandom_range(0, 99);
      clock_ms = ($urandom_range(0, 49) == 0) ? $urandom : clock_ms + $urandom_range(0, 300);
      r = $urandom_range(0, 99);
      c = r < 35 ? CMD_SEND : (r < 60 ? CMD_ACK : (r < 75 ? CMD_TIMEOUT : CMD_QUERY));
      size = ($urandom_range(0, 9) == 0) ? 11'd1024 : 11'($urandom_range(0, 1024));
      seq = 15'($urandom);
      if (c == CMD_SEND && $urandom_range(0, 9) != 0) seq = next_seq;
      if (c == CMD_ACK && pt_cnt > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, pt_cnt - 1);
        seq = pt_seq[k];
      end
      if (c == CMD_SEND) next_seq = 15'(seq + size);
      issue_cmd(c, clock_ms, seq, size, 8'($urandom));
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    outcome_t exp_o, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[24:9], m_axis_tdata[25],
             m_axis_tdata[26], m_axis_tdata[27]};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        exp_o = expected_q.pop_front();
        if (got != exp_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp h=%0d v=%0d wait=%0d e=%0d u=%0d o=%0d",
                     exp_o.handle, exp_o.handle_valid, exp_o.wait_ms, exp_o.empty,
                     exp_o.unmatched, exp_o.overflow,
                     " / got h=%0d v=%0d wait=%0d e=%0d u=%0d o=%0d",
                     got.handle, got.handle_valid, got.wait_ms, got.empty,
                     got.unmatched, got.overflow);
        end
      end
    end
  end

  // receiver with random stalls and an occasional long hold-off
  always @(negedge clk_i) begin
    int unsigned r;
    if (hold_request > 0) begin
      m_axis_tready <= 1'b0;
      hold_request <= hold_request - 1;
    end else if (idle_on) begin
      r = $urandom_range(0, 99);
      m_axis_tready <= r >= 25;
      if (r < 2) hold_request <= $urandom_range(20, 80);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    trk_head = 0; trk_cnt = 0; pt_cnt = 0;
    next_pnum = 1; acked_pnum = 0; start_pending = 1'b1;
    tmo_reg = TimeoutReset; space_reg = SpaceReset;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_cases();
    test_pair_full();
    test_ring_full();
    test_random(420, 1'b1);
    write_reg(REG_TIMEOUT, 16'd1);
    write_reg(REG_SPACE, 16'd1);
    idle_on = 1'b0;
    test_random(420, 1'b0);
    idle_on = 1'b1;
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_SPACE, 16'hFFFF);
    test_random(420, 1'b0);
    write_reg(REG_TIMEOUT, 16'($urandom_range(1, 2000)));
    write_reg(REG_SPACE, 16'd32768);
    test_random(200, 1'b1);
    write_reg(REG_SPACE, 16'd0);
    test_random(200, 1'b0);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/rit_pkg.sv
rtl/core/retransmit_inflight_tracker.sv
tb/testbench.sv
